FILE: hw/rtl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// shared types and constants of the rangefinder frame parser
// ----------------------------------------------------------------------------
package rfp_pkg;

    // frame layout, byte positions
    localparam logic [3:0] POS_HDR0     = 4'd0;
    localparam logic [3:0] POS_HDR1     = 4'd1;
    localparam logic [3:0] POS_ID       = 4'd3;
    localparam logic [3:0] POS_TIME0    = 4'd4;
    localparam logic [3:0] POS_TIME3    = 4'd7;
    localparam logic [3:0] POS_DIST0    = 4'd8;
    localparam logic [3:0] POS_DIST2    = 4'd10;
    localparam logic [3:0] POS_STATUS   = 4'd11;
    localparam logic [3:0] POS_STRENGTH0 = 4'd12;
    localparam logic [3:0] POS_STRENGTH1 = 4'd13;
    localparam logic [3:0] POS_CHECKSUM = 4'd15;

    localparam logic [7:0] HDR0_BYTE = 8'h57;
    localparam logic [7:0] HDR1_BYTE = 8'h00;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DISTANCE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE = 8'd1;

    localparam logic [15:0] MIN_DISTANCE_RESET = 16'd20;
    localparam logic [15:0] MAX_DISTANCE_RESET = 16'd5000;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [15:0] tilt_cosine;
    } in_beat_t;

    typedef struct packed {
        logic        reading_valid;
        logic [23:0] distance_mm;
        logic [15:0] height_mm;
        logic [7:0]  sensor_id;
        logic [31:0] sensor_time;
        logic [7:0]  range_status;
        logic [15:0] signal_strength;
    } out_beat_t;

    // fields of a frame with a good checksum
    typedef struct packed {
        logic [7:0]  sensor_id;
        logic [31:0] sensor_time;
        logic [23:0] distance_mm;
        logic [7:0]  range_status;
        logic [15:0] signal_strength;
        logic [15:0] tilt_cosine;
    } frame_t;

    typedef struct packed {
        logic [15:0] min_distance_mm;
        logic [15:0] max_distance_mm;
    } limits_t;

endpackage

FILE: hw/rtl/rfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// rfp_cfg_regs
// distance limit registers behind the configuration write channel
// ----------------------------------------------------------------------------
module rfp_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [rfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data,
    output rfp_pkg::limits_t                  limits
);

    logic [15:0] min_reg, min_next;
    logic [15:0] max_reg, max_next;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                rfp_pkg::REG_MIN_DISTANCE: min_next = cfg_data;
                rfp_pkg::REG_MAX_DISTANCE: max_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= rfp_pkg::MIN_DISTANCE_RESET;
            max_reg <= rfp_pkg::MAX_DISTANCE_RESET;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign limits.min_distance_mm = min_reg;
    assign limits.max_distance_mm = max_reg;

endmodule

FILE: hw/rtl/rfp_frame_assembler.sv
// ----------------------------------------------------------------------------
// rfp_frame_assembler
// byte position tracking, running checksum and field capture
// ----------------------------------------------------------------------------
module rfp_frame_assembler (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat_accept,
    input  rfp_pkg::in_beat_t beat,
    output logic              frame_good,
    output rfp_pkg::frame_t   frame
);

    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  id_reg, id_next;
    logic [31:0] time_reg, time_next;
    logic [23:0] dist_reg, dist_next;
    logic [7:0]  status_reg, status_next;
    logic [15:0] strength_reg, strength_next;
    logic [7:0]  sum_base;
    logic [7:0]  hdr_want;

    always_comb begin
        sum_base      = (pos_reg == rfp_pkg::POS_HDR0) ? 8'd0 : sum_reg;
        hdr_want      = (pos_reg == rfp_pkg::POS_HDR0) ? rfp_pkg::HDR0_BYTE
                                                       : rfp_pkg::HDR1_BYTE;
        pos_next      = pos_reg + 4'd1;
        sum_next      = sum_base + beat.rx_byte;
        id_next       = id_reg;
        time_next     = time_reg;
        dist_next     = dist_reg;
        status_next   = status_reg;
        strength_next = strength_reg;

        case (pos_reg) inside
            rfp_pkg::POS_HDR0, rfp_pkg::POS_HDR1: begin
                // mismatch restarts the search, byte is not retried as header
                if (beat.rx_byte != hdr_want) begin
                    pos_next = rfp_pkg::POS_HDR0;
                    sum_next = sum_base;
                end
            end
            rfp_pkg::POS_ID: id_next = beat.rx_byte;
            [rfp_pkg::POS_TIME0:rfp_pkg::POS_TIME3]:
                time_next[{pos_reg[1:0], 3'b000} +: 8] = beat.rx_byte;
            [rfp_pkg::POS_DIST0:rfp_pkg::POS_DIST2]:
                dist_next[{pos_reg[1:0], 3'b000} +: 8] = beat.rx_byte;
            rfp_pkg::POS_STATUS: status_next = beat.rx_byte;
            rfp_pkg::POS_STRENGTH0, rfp_pkg::POS_STRENGTH1:
                strength_next[{pos_reg[0], 3'b000} +: 8] = beat.rx_byte;
            rfp_pkg::POS_CHECKSUM: begin
                pos_next = rfp_pkg::POS_HDR0;
                sum_next = sum_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 4'd0;
            sum_reg      <= 8'd0;
            id_reg       <= 8'd0;
            time_reg     <= 32'd0;
            dist_reg     <= 24'd0;
            status_reg   <= 8'd0;
            strength_reg <= 16'd0;
        end else if (beat_accept) begin
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            id_reg       <= id_next;
            time_reg     <= time_next;
            dist_reg     <= dist_next;
            status_reg   <= status_next;
            strength_reg <= strength_next;
        end
    end

    assign frame_good = beat_accept && (pos_reg == rfp_pkg::POS_CHECKSUM)
                        && (sum_reg == beat.rx_byte);

    assign frame.sensor_id       = id_reg;
    assign frame.sensor_time     = time_reg;
    assign frame.distance_mm     = dist_reg;
    assign frame.range_status    = status_reg;
    assign frame.signal_strength = strength_reg;
    assign frame.tilt_cosine     = beat.tilt_cosine;

endmodule

FILE: hw/rtl/rfp_reading_eval.sv
// ----------------------------------------------------------------------------
// rfp_reading_eval
// frame register, validity check, tilt scaling and result register
// ----------------------------------------------------------------------------
module rfp_reading_eval (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               frame_good,
    input  rfp_pkg::frame_t    frame,
    input  rfp_pkg::limits_t   limits,
    output logic               frame_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output rfp_pkg::out_beat_t m_data
);

    logic               s1_valid_reg;
    rfp_pkg::frame_t    s1_frame_reg;
    logic               out_valid_reg;
    rfp_pkg::out_beat_t out_data_reg;
    rfp_pkg::out_beat_t result;
    logic               out_ready;
    logic               in_range;
    logic [24:0]        dist_ext;
    logic [24:0]        min_ext;
    logic [24:0]        max_ext;
    logic [31:0]        prod;
    logic [16:0]        height_raw;

    assign out_ready   = !out_valid_reg || m_ready;
    assign frame_ready = !s1_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (frame_ready) begin
            s1_valid_reg <= frame_good;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_ready && frame_good) begin
            s1_frame_reg <= frame;
        end
    end

    always_comb begin
        dist_ext = {s1_frame_reg.distance_mm[23], s1_frame_reg.distance_mm};
        min_ext  = {9'd0, limits.min_distance_mm};
        max_ext  = {9'd0, limits.max_distance_mm};
        in_range = ($signed(dist_ext) > $signed(min_ext))
                   && ($signed(dist_ext) < $signed(max_ext));
        // a valid distance is below the upper limit, so 16 bits carry it
        prod       = {16'd0, s1_frame_reg.distance_mm[15:0]}
                     * {16'd0, s1_frame_reg.tilt_cosine};
        height_raw = prod[31:15];

        result.reading_valid   = in_range && (s1_frame_reg.signal_strength != 16'd0);
        result.distance_mm     = s1_frame_reg.distance_mm;
        result.sensor_id       = s1_frame_reg.sensor_id;
        result.sensor_time     = s1_frame_reg.sensor_time;
        result.range_status    = s1_frame_reg.range_status;
        result.signal_strength = s1_frame_reg.signal_strength;
        if (!result.reading_valid) begin
            result.height_mm = 16'd0;
        end else if (height_raw[16]) begin
            result.height_mm = 16'hFFFF;
        end else begin
            result.height_mm = height_raw[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s1_valid_reg) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: hw/rtl/rangefinder_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// rangefinder_frame_parser_unit
// parses 16-byte rangefinder frames from a byte stream into readings
// ----------------------------------------------------------------------------
// throughput: one byte beat per cycle, sustained, stalls only on output backpressure
// path: after its checksum beat is accepted, a frame goes to the frame register,
//   then to the result register after the tilt multiply
// reset: synchronous active-low aresetn clears parser position, checksum and
//   held fields, loads the limits to 20 mm and 5000 mm, and empties both stages
// ----------------------------------------------------------------------------
module rangefinder_frame_parser_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // byte stream in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rfp_pkg::in_beat_t               s_data,
    // readings out
    output logic                            m_valid,
    input  logic                            m_ready,
    output rfp_pkg::out_beat_t              m_data,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                     cfg_data
);

    logic             beat_accept;
    logic             frame_good;
    logic             frame_ready;
    rfp_pkg::frame_t  frame;
    rfp_pkg::limits_t limits;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // a byte beat is taken whenever the frame register can take a frame,
    // so a checksum beat never gets lost behind a full pipeline
    assign s_ready     = frame_ready;
    assign beat_accept = s_valid && s_ready;

    // distance limits
    rfp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    // header search, running sum and field capture
    rfp_frame_assembler u_assembler (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (beat_accept),
        .beat        (s_data),
        .frame_good  (frame_good),
        .frame       (frame)
    );

    // validity, tilt-compensated height and output register
    rfp_reading_eval u_eval (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_good  (frame_good),
        .frame       (frame),
        .limits      (limits),
        .frame_ready (frame_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

FILE: hw/rtl/rfp_port_checker.sv
// ----------------------------------------------------------------------------
// rfp_port_checker
// port-level checks of the rangefinder frame parser, bound to the top level
// ----------------------------------------------------------------------------
module rfp_port_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input rfp_pkg::out_beat_t m_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // unavailable sensor reports zero height
    a_height_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.reading_valid |-> m_data.height_mm == 16'd0)
        else $error("height nonzero on invalid reading");

    // a valid reading has strength and a non-negative distance
    a_valid_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.reading_valid |->
            m_data.signal_strength != 16'd0 && !m_data.distance_mm[23])
        else $error("valid reading with zero strength or negative distance");

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind rangefinder_frame_parser_unit rfp_port_checker u_port_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
